// ===== src/tbah_pkg.sv =====
package tbah_pkg;

   localparam int FRAC_BITS    = 20;
   localparam int MAX_HALVINGS = 24;

   localparam int ANGLE_W = 22;
   localparam int TAN_W   = 24;
   localparam int TOL_W   = 21;

   localparam int CNT_W  = $clog2(MAX_HALVINGS + 1);
   localparam int MUL_W  = TAN_W - 1;
   localparam int PROD_W = 2 * MUL_W - FRAC_BITS;
   localparam int DEN_W  = FRAC_BITS + 1;
   localparam int NUM_W  = TAN_W + FRAC_BITS;
   localparam int QUO_W  = TAN_W - 1;
   localparam int QCNT_W = $clog2(QUO_W);

   localparam int SEED_DIVISOR = 6;
   localparam int TOL_RESET    = 1049;

   // The seed divides the cube by six as floor(floor(x/2) * SEED_RECIP / 2^SEED_RECIP_SHIFT),
   // with SEED_RECIP = ceil(2^24 / 3). This is exact while floor(x/2) stays below 2^23.
   localparam int SEED_RECIP       = 5592406;
   localparam int SEED_RECIP_SHIFT = 24;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
   localparam logic [OP_W-1:0] OP_HALVE     = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL_SQ    = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL_CUBE  = 4'd4;
   localparam logic [OP_W-1:0] OP_MUL_A     = 4'd5;
   localparam logic [OP_W-1:0] OP_DIV_SEED  = 4'd6;
   localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd7;
   localparam logic [OP_W-1:0] OP_DIV_ITER  = 4'd8;
   localparam logic [OP_W-1:0] OP_SEED_SET  = 4'd9;
   localparam logic [OP_W-1:0] OP_STEP_SET  = 4'd10;
   localparam logic [OP_W-1:0] OP_SET_OVF   = 4'd11;
   localparam logic [OP_W-1:0] OP_OUT       = 4'd12;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic halve_go;
      logic count_zero;
      logic den_bad;
      logic div_ovf;
      logic div_last;
   } dp_status_type;

endpackage

// ===== src/tbah_datapath.sv =====
module tbah_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tbah_pkg::dp_cmd_type                cmd,
   output tbah_pkg::dp_status_type             status,
   input  logic [tbah_pkg::TOL_W-1:0]          tolerance,
   input  logic signed [tbah_pkg::ANGLE_W-1:0] req_angle,
   output logic signed [tbah_pkg::TAN_W-1:0]   rsp_tangent,
   output logic                                rsp_overflow
);

   logic                               neg_ff, neg_in;
   logic [tbah_pkg::ANGLE_W-1:0]       m_ff, m_in;
   logic [tbah_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [tbah_pkg::MUL_W-1:0]         a_ff, a_in;
   logic [tbah_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [tbah_pkg::NUM_W-1:0]         r_ff, r_in;
   logic [tbah_pkg::NUM_W-1:0]         d_ff, d_in;
   logic [tbah_pkg::QUO_W-1:0]         q_ff, q_in;
   logic [tbah_pkg::QCNT_W-1:0]        qcnt_ff, qcnt_in;
   logic                               ovf_ff, ovf_in;
   logic [tbah_pkg::TAN_W-1:0]         tangent_ff, tangent_in;
   logic                               overflow_ff, overflow_in;

   logic [tbah_pkg::ANGLE_W-1:0]       raw;
   logic [tbah_pkg::MUL_W-1:0]         m_ext;
   logic [tbah_pkg::MUL_W-1:0]         mul_x, mul_y;
   logic [2*tbah_pkg::MUL_W-1:0]       product;
   logic [tbah_pkg::DEN_W-1:0]         den_val;
   logic                               div_ge;
   logic [tbah_pkg::TAN_W-1:0]         a_wide;

   assign raw   = req_angle;
   assign m_ext = tbah_pkg::MUL_W'(m_ff);

   // One shared multiplier serves the series seed and every doubling step.
   always_comb begin
      case (cmd.op)
         tbah_pkg::OP_MUL_SQ: begin
            mul_x = m_ext;
            mul_y = m_ext;
         end
         tbah_pkg::OP_MUL_CUBE: begin
            mul_x = prod_ff[tbah_pkg::MUL_W-1:0];
            mul_y = m_ext;
         end
         // The cube is halved first so the reciprocal of three finishes the division.
         tbah_pkg::OP_DIV_SEED: begin
            mul_x = prod_ff[tbah_pkg::MUL_W:1];
            mul_y = tbah_pkg::MUL_W'(tbah_pkg::SEED_RECIP);
         end
         default: begin
            mul_x = a_ff;
            mul_y = a_ff;
         end
      endcase
   end

   assign product = mul_x * mul_y;

   assign den_val = {1'b1, {tbah_pkg::FRAC_BITS{1'b0}}}
                    - {1'b0, prod_ff[tbah_pkg::FRAC_BITS-1:0]};
   assign div_ge  = (r_ff >= d_ff);
   assign a_wide  = {1'b0, a_ff};

   assign status.halve_go   = (count_ff < tbah_pkg::CNT_W'(tbah_pkg::MAX_HALVINGS))
                              && (m_ff >= tbah_pkg::ANGLE_W'(tolerance));
   assign status.count_zero = (count_ff == '0);
   assign status.den_bad    = |prod_ff[tbah_pkg::PROD_W-1:tbah_pkg::FRAC_BITS];
   // A quotient of 2^QUO_W or more cannot be represented and saturates.
   assign status.div_ovf    = ({1'b0, r_ff} >= {d_ff, 1'b0});
   assign status.div_last   = (qcnt_ff == '0);

   always_comb begin
      neg_in      = neg_ff;
      m_in        = m_ff;
      count_in    = count_ff;
      a_in        = a_ff;
      prod_in     = prod_ff;
      r_in        = r_ff;
      d_in        = d_ff;
      q_in        = q_ff;
      qcnt_in     = qcnt_ff;
      ovf_in      = ovf_ff;
      tangent_in  = tangent_ff;
      overflow_in = overflow_ff;
      case (cmd.op)
         tbah_pkg::OP_LOAD: begin
            neg_in   = raw[tbah_pkg::ANGLE_W-1];
            m_in     = raw[tbah_pkg::ANGLE_W-1] ? (~raw + 1'b1) : raw;
            count_in = '0;
            ovf_in   = 1'b0;
         end
         tbah_pkg::OP_HALVE: begin
            m_in     = m_ff >> 1;
            count_in = count_ff + 1'b1;
         end
         tbah_pkg::OP_MUL_SQ, tbah_pkg::OP_MUL_CUBE, tbah_pkg::OP_MUL_A: begin
            prod_in = product[2*tbah_pkg::MUL_W-1:tbah_pkg::FRAC_BITS];
         end
         tbah_pkg::OP_DIV_SEED: begin
            q_in = tbah_pkg::QUO_W'(product[2*tbah_pkg::MUL_W-1:tbah_pkg::SEED_RECIP_SHIFT]);
         end
         tbah_pkg::OP_DIV_STEP: begin
            r_in    = {a_ff, {(tbah_pkg::FRAC_BITS+1){1'b0}}};
            d_in    = tbah_pkg::NUM_W'({den_val, {(tbah_pkg::QUO_W-1){1'b0}}});
            q_in    = '0;
            qcnt_in = tbah_pkg::QCNT_W'(tbah_pkg::QUO_W - 1);
         end
         tbah_pkg::OP_DIV_ITER: begin
            r_in    = div_ge ? (r_ff - d_ff) : r_ff;
            d_in    = d_ff >> 1;
            q_in    = {q_ff[tbah_pkg::QUO_W-2:0], div_ge};
            qcnt_in = qcnt_ff - 1'b1;
         end
         tbah_pkg::OP_SEED_SET: begin
            a_in = m_ext - q_ff;
         end
         tbah_pkg::OP_STEP_SET: begin
            a_in     = q_ff;
            count_in = count_ff - 1'b1;
         end
         tbah_pkg::OP_SET_OVF: begin
            ovf_in = 1'b1;
         end
         tbah_pkg::OP_OUT: begin
            overflow_in = ovf_ff;
            if (ovf_ff) begin
               tangent_in = neg_ff ? {1'b1, {(tbah_pkg::TAN_W-1){1'b0}}}
                                   : {1'b0, {(tbah_pkg::TAN_W-1){1'b1}}};
            end else begin
               tangent_in = neg_ff ? (~a_wide + 1'b1) : a_wide;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      m_ff        <= m_in;
      count_ff    <= count_in;
      a_ff        <= a_in;
      prod_ff     <= prod_in;
      r_ff        <= r_in;
      d_ff        <= d_in;
      q_ff        <= q_in;
      qcnt_ff     <= qcnt_in;
      ovf_ff      <= ovf_in;
      tangent_ff  <= tangent_in;
      overflow_ff <= overflow_in;
   end

   assign rsp_tangent  = tangent_ff;
   assign rsp_overflow = overflow_ff;

   a_halve_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tbah_pkg::OP_HALVE)
      |-> (count_ff < tbah_pkg::CNT_W'(tbah_pkg::MAX_HALVINGS)))
      else $error("halving past the limit");

   a_step_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tbah_pkg::OP_STEP_SET) |-> (count_ff != '0))
      else $error("doubling step with no halving left");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tbah_pkg::OP_DIV_ITER) |-> ({1'b0, r_ff} < {d_ff, 1'b0}))
      else $error("divider remainder out of range");

endmodule

// ===== src/tbah_ctrl.sv =====
module tbah_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tbah_pkg::dp_cmd_type    cmd,
   input  tbah_pkg::dp_status_type status
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_HALVE     = 4'd1;
   localparam logic [3:0] S_CUBE      = 4'd2;
   localparam logic [3:0] S_SEED_DIV  = 4'd3;
   localparam logic [3:0] S_DIV_CHECK = 4'd4;
   localparam logic [3:0] S_DIV_ITER  = 4'd5;
   localparam logic [3:0] S_DIV_DONE  = 4'd6;
   localparam logic [3:0] S_LOOP      = 4'd7;
   localparam logic [3:0] S_DEN       = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       seed_ff, seed_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_load;

   always_comb begin
      state_in = state_ff;
      seed_in  = seed_ff;
      cmd.op   = tbah_pkg::OP_NOP;
      rsp_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = tbah_pkg::OP_LOAD;
               state_in = S_HALVE;
            end
         end
         S_HALVE: begin
            if (status.halve_go) begin
               cmd.op = tbah_pkg::OP_HALVE;
            end else begin
               cmd.op   = tbah_pkg::OP_MUL_SQ;
               state_in = S_CUBE;
            end
         end
         S_CUBE: begin
            cmd.op   = tbah_pkg::OP_MUL_CUBE;
            seed_in  = 1'b1;
            state_in = S_SEED_DIV;
         end
         // The division by six is a single reciprocal multiply.
         S_SEED_DIV: begin
            cmd.op   = tbah_pkg::OP_DIV_SEED;
            state_in = S_DIV_DONE;
         end
         S_DIV_CHECK: begin
            if (status.div_ovf) begin
               cmd.op   = tbah_pkg::OP_SET_OVF;
               state_in = S_FINISH;
            end else begin
               state_in = S_DIV_ITER;
            end
         end
         S_DIV_ITER: begin
            cmd.op = tbah_pkg::OP_DIV_ITER;
            if (status.div_last) begin
               state_in = S_DIV_DONE;
            end
         end
         S_DIV_DONE: begin
            cmd.op   = seed_ff ? tbah_pkg::OP_SEED_SET : tbah_pkg::OP_STEP_SET;
            seed_in  = 1'b0;
            state_in = S_LOOP;
         end
         S_LOOP: begin
            if (status.count_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.op   = tbah_pkg::OP_MUL_A;
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            if (status.den_bad) begin
               cmd.op   = tbah_pkg::OP_SET_OVF;
               state_in = S_FINISH;
            end else begin
               cmd.op   = tbah_pkg::OP_DIV_STEP;
               state_in = S_DIV_CHECK;
            end
         end
         S_FINISH: begin
            // The result register is reloaded only once the previous beat is gone.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = tbah_pkg::OP_OUT;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_HALVE))
      else $error("accepted beat did not start the halving phase");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tbah_pkg::OP_OUT) |=> rsp_valid_ff)
      else $error("result loaded without valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == tbah_pkg::OP_OUT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

// ===== src/tangent_by_angle_halving.sv =====
// Fixed-point tangent by angle halving and double-angle recursion.
//
// The request channel carries one signed angle per beat (20 fractional bits).
// The response channel returns a 24-bit tangent, 20 fractional bits, plus an
// overflow flag, set when a denominator was not positive or the value
// saturated. The tolerance register sits at byte address 0 of the CSR port.
//
// One item is worked on at a time. With H halvings, the work after the
// accepting edge is H halving steps, three shared multiplier passes for
// the square, the cube and the division by six, and per doubling step a
// square, a check and a restoring divider. The divider dominates; at the
// reset tolerance and unit angles H is ten, and H is at most 24.
//
// The finished result waits in an output register while the next beat can
// already be accepted; a stalled receiver only holds off the final load.
// Reset returns the controller to idle, drops any pending response and
// restores the tolerance to its reset value.
module tangent_by_angle_halving (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tbah_pkg::ANGLE_W-1:0]    req_angle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tbah_pkg::TAN_W-1:0]      rsp_tangent,
   output logic                                   rsp_overflow,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [tbah_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [tbah_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [tbah_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   logic [tbah_pkg::TOL_W-1:0] tol_ff, tol_in;
   logic                       csr_wr;
   tbah_pkg::dp_cmd_type       cmd;
   tbah_pkg::dp_status_type    status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && !csr_paddr[2];

   assign tol_in = csr_wr ? csr_pwdata[tbah_pkg::TOL_W-1:0] : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= tbah_pkg::TOL_W'(tbah_pkg::TOL_RESET);
      end else begin
         tol_ff <= tol_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? '0 : tbah_pkg::CSR_DATA_W'(tol_ff);

   tbah_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   tbah_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .tolerance    (tol_ff),
      .req_angle    (req_angle),
      .rsp_tangent  (rsp_tangent),
      .rsp_overflow (rsp_overflow)
   );

endmodule
